// ===== sv/tdpt_pkg.sv =====
`default_nettype none

package tdpt_pkg;

    // Width of the number under test
    localparam int NUM_WIDTH = 32;
    // Divisor width: holds any divisor up to one past the integer square root
    localparam int DIV_WIDTH = NUM_WIDTH / 2 + 1;
    // Width of the running divisor square
    localparam int SQ_WIDTH  = 2 * DIV_WIDTH;
    // Bit counter width for the serial remainder
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

    // First odd divisor and its square
    localparam logic [DIV_WIDTH-1:0] FIRST_DIV = DIV_WIDTH'(3);
    localparam logic [SQ_WIDTH-1:0]  FIRST_SQ  = SQ_WIDTH'(9);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture a new number
        logic init_div;  // start a remainder pass with the current divisor
        logic div_step;  // one bit of the remainder pass
        logic next_d;    // advance to the next odd divisor
    } tdpt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic lt2;       // number is 0 or 1
        logic lt4;       // number is below 4
        logic even;      // number is even
        logic sq_gt_n;   // divisor squared exceeds number
        logic rem_zero;  // remainder of last pass is zero
        logic div_last;  // current step is the last bit of the pass
    } tdpt_sts_t;

endpackage

`default_nettype wire

// ===== sv/tdpt_num_if.sv =====
`default_nettype none

interface tdpt_num_if;
    import tdpt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [NUM_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

// ===== sv/tdpt_res_if.sv =====
`default_nettype none

interface tdpt_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// ===== sv/tdpt_dp.sv =====
`default_nettype none

module tdpt_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tdpt_pkg::tdpt_cmd_t                cmd,
    input  wire logic [tdpt_pkg::NUM_WIDTH-1:0]     number,
    output tdpt_pkg::tdpt_sts_t                     sts
);
    import tdpt_pkg::*;

    logic [NUM_WIDTH-1:0] n_reg,   n_next;
    logic [DIV_WIDTH-1:0] d_reg,   d_next;
    logic [SQ_WIDTH-1:0]  sq_reg,  sq_next;
    logic [DIV_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] sh_reg,  sh_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;

    logic [DIV_WIDTH:0]   rem_shift;
    logic [DIV_WIDTH:0]   rem_sub;

    // One restoring-division step: shift in next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, sh_reg[NUM_WIDTH-1]};
    assign rem_sub   = rem_shift - {1'b0, d_reg};

    // Next-value logic
    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        rem_next = rem_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            n_next  = number;
            d_next  = FIRST_DIV;
            sq_next = FIRST_SQ;
        end
        if (cmd.init_div)
        begin
            rem_next = '0;
            sh_next  = n_reg;
            cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next = rem_sub[DIV_WIDTH] ? rem_shift[DIV_WIDTH-1:0] : rem_sub[DIV_WIDTH-1:0];
            sh_next  = {sh_reg[NUM_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_WIDTH'(1);
        end
        if (cmd.next_d)
        begin
            // (d+2)^2 = d^2 + 4d + 4
            d_next  = d_reg + DIV_WIDTH'(2);
            sq_next = sq_reg + (SQ_WIDTH'(d_reg) << 2) + SQ_WIDTH'(4);
        end
    end

    // Datapath registers (payload only, no reset needed)
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
    end

    // Status back to the controller
    always_comb
    begin
        sts.lt2      = (n_reg < NUM_WIDTH'(2));
        sts.lt4      = (n_reg < NUM_WIDTH'(4));
        sts.even     = ~n_reg[0];
        sts.sq_gt_n  = (sq_reg > SQ_WIDTH'(n_reg));
        sts.rem_zero = (rem_reg == '0);
        sts.div_last = (cnt_reg == CNT_WIDTH'(NUM_WIDTH - 1));
    end

    // Running square tracks the divisor
    a_sq_tracks_d: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load || cmd.next_d) |=> (sq_reg == SQ_WIDTH'(SQ_WIDTH'(d_reg) * SQ_WIDTH'(d_reg))))
        else $error("divisor square out of step with divisor");

    // Divisor stays odd on each advance to the next divisor
    a_d_odd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.next_d |=> d_reg[0])
        else $error("even divisor");

endmodule

`default_nettype wire

// ===== sv/tdpt_ctrl.sv =====
`default_nettype none

module tdpt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       out_bit,
    input  wire tdpt_pkg::tdpt_sts_t   sts,
    output tdpt_pkg::tdpt_cmd_t        cmd
);
    import tdpt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_BOUND,
        ST_DIV,
        ST_TEST,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   res_reg, res_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_bit_reg, out_bit_next;
    logic   in_accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_bit_next   = out_bit_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                priority if (sts.lt2)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (sts.lt4)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.even)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                if (sts.sq_gt_n)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.init_div = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (sts.rem_zero)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.next_d = 1'b1;
                    state_next = ST_BOUND;
                end
            end
            ST_DONE:
            begin
                // hand off to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_bit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_bit_reg   <= out_bit_next;
        end
    end

    a_accept_classify: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_CLASSIFY))
        else $error("accepted beat not classified");

    a_div_to_test: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_TEST))
        else $error("remainder pass did not end");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && out_valid_next) |-> (state_reg == ST_DONE))
        else $error("result beat issued outside done state");

endmodule

`default_nettype wire

// ===== sv/trial_division_prime_test_unit.sv =====
// Trial-division primality tester.
//
// Channels: req (sink) carries one number per beat; rsp (source) returns
// one is_prime bit per request, in order. Beats move on valid && ready.
// req.ready is high only while the unit is idle; one number is tested at
// a time.
//
// Timing: small cases (below 4, or even) are decided in the classify
// state and go straight to done. Odd numbers run each odd divisor d = 3,
// 5, ... while d*d <= number, until one divides it; each divisor passes
// a bound check, a bit-serial restoring remainder of NUM_WIDTH steps and
// a zero test. The serial remainder sets the rate: the worst case, a
// 32-bit prime near 2^32, needs about 32768 divisors.
//
// The result sits in an output register; the next number is accepted
// while it waits. If rsp stalls with a result still held, a finished test
// waits in its done state and req.ready stays low until the slot frees.
//
// Reset (rst_n, async, active low) returns to idle with rsp.valid low.

`default_nettype none

module trial_division_prime_test_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tdpt_num_if.sink    req,
    tdpt_res_if.source  rsp
);
    import tdpt_pkg::*;

    tdpt_cmd_t cmd;
    tdpt_sts_t sts;
    logic      in_ready;
    logic      out_valid;
    logic      out_bit;

    tdpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .out_bit   (out_bit),
        .sts       (sts),
        .cmd       (cmd)
    );

    tdpt_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .number (req.number),
        .sts    (sts)
    );

    assign req.ready    = in_ready;
    assign rsp.valid    = out_valid;
    assign rsp.is_prime = out_bit;

endmodule

`default_nettype wire
